[hw/rtl/modular_division_fermat_assert.svh]
// assertion macros shared by the checker files of the modular division block
// depends on nothing; each macro expects i_clk and i_rst_n in scope
`ifndef MODULAR_DIVISION_FERMAT_ASSERT_SVH
`define MODULAR_DIVISION_FERMAT_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define MDF_ASSERT_NOW(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cond)) \
        else $error("modular division check failed");

// condition holds in the cycle after the trigger
`define MDF_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cond)) \
        else $error("modular division check failed");

`endif

[hw/rtl/mdf_pkg.sv]
// shared constants and types for the modular division block
// used by mdf_mulmod, modular_division_fermat and mdf_checker
package mdf_pkg;

    // default operand width and modulus after reset
    localparam int          MOD_WIDTH_DEF = 31;
    localparam longint      RESET_MODULUS = 64'd1000000007;

    // configuration port: one register, indexed by paddr bit 2
    localparam int          APB_AW        = 3;
    localparam logic        REG_MODULUS   = 1'b0;

    // status of the shared modular multiplier
    typedef struct packed {
        logic busy;
        logic done;
    } t_mm_stat;

endpackage

[hw/rtl/modular_division_fermat.sv]
// modular division top level: quotient = dividend * divisor^(m-2) mod m
// depends on mdf_pkg and mdf_mulmod
//
// usage
//   s channel: one beat carries dividend (low MOD_WIDTH bits of tdata) and
//   divisor (next MOD_WIDTH bits); both are reduced modulo m first.
//   m channel: one beat per input beat carrying the quotient.
//   apb port: register 0 (address 0) holds the modulus m, reset 1000000007.
//   a divisor that is zero mod m, or m below 2, gives a quotient of 0.
// timing
//   every operation runs on one bit-serial modular multiplier. an item needs
//   two reductions, up to MOD_WIDTH-1 squarings, up to MOD_WIDTH multiplies
//   and one final product. the block takes one item at a time: s tready is
//   low from acceptance until the result beat is taken.
// reset and stall
//   reset returns the sequencer to idle, drops m tvalid and reloads the
//   modulus. while m tready is low the result is held in its output register.
module modular_division_fermat import mdf_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // s channel
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // fields from bit 0: dividend, divisor
    input  logic [((2*MOD_WIDTH+7)/8)*8-1:0]       i_s_tdata,
    // m channel
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // fields from bit 0: quotient
    output logic [((MOD_WIDTH+7)/8)*8-1:0]         o_m_tdata,
    // configuration port
    input  logic                                   i_psel,
    input  logic                                   i_penable,
    input  logic                                   i_pwrite,
    input  logic [APB_AW-1:0]                      i_paddr,
    input  logic [((MOD_WIDTH>32)?64:32)-1:0]      i_pwdata,
    output logic [((MOD_WIDTH>32)?64:32)-1:0]      o_prdata,
    output logic                                   o_pready
);

    localparam int OUT_W = ((MOD_WIDTH + 7) / 8) * 8;
    localparam int PW    = (MOD_WIDTH > 32) ? 64 : 32;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RED_A,
        S_RED_B,
        S_STEP,
        S_MACC,
        S_MSQ,
        S_FIN,
        S_OUT
    } t_state;

    t_state               r_state;
    logic [MOD_WIDTH-1:0] r_mod;
    logic [MOD_WIDTH-1:0] r_braw;
    logic [MOD_WIDTH-1:0] r_a;
    logic [MOD_WIDTH-1:0] r_acc;
    logic [MOD_WIDTH-1:0] r_base;
    logic [MOD_WIDTH-1:0] r_exp;
    logic [MOD_WIDTH-1:0] r_q;
    logic                 r_go;
    logic [MOD_WIDTH-1:0] r_opx;
    logic [MOD_WIDTH-1:0] r_opy;

    t_mm_stat             s_mm;
    logic [MOD_WIDTH-1:0] w_res;
    logic                 w_in_beat;
    logic                 w_cfg_wr;

    assign w_in_beat = i_s_tvalid && o_s_tready;
    assign w_cfg_wr  = i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_MODULUS);

    // shared modular multiplier
    mdf_mulmod #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_go),
        .i_x     (r_opx),
        .i_y     (r_opy),
        .i_mod   (r_mod),
        .o_stat  (s_mm),
        .o_res   (w_res)
    );

    // modulus register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod <= MOD_WIDTH'(RESET_MODULUS);
        end else if (w_cfg_wr) begin
            r_mod <= i_pwdata[MOD_WIDTH-1:0];
        end
    end

    assign o_prdata = (i_paddr[2] == REG_MODULUS) ? PW'(r_mod) : '0;
    assign o_pready = 1'b1;

    // sequencer: reduce both operands, square-and-multiply, final product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_go    <= 1'b0;
        end else begin
            r_go <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        if (r_mod < MOD_WIDTH'(2)) begin
                            r_q     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_braw  <= i_s_tdata[2*MOD_WIDTH-1:MOD_WIDTH];
                            r_opx   <= MOD_WIDTH'(1);
                            r_opy   <= i_s_tdata[MOD_WIDTH-1:0];
                            r_go    <= 1'b1;
                            r_state <= S_RED_A;
                        end
                    end
                end
                S_RED_A: begin
                    if (s_mm.done) begin
                        r_a     <= w_res;
                        r_opx   <= MOD_WIDTH'(1);
                        r_opy   <= r_braw;
                        r_go    <= 1'b1;
                        r_state <= S_RED_B;
                    end
                end
                S_RED_B: begin
                    if (s_mm.done) begin
                        if (w_res == '0) begin
                            r_q     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_base  <= w_res;
                            r_acc   <= MOD_WIDTH'(1);
                            r_exp   <= r_mod - MOD_WIDTH'(2);
                            r_state <= S_STEP;
                        end
                    end
                end
                S_STEP: begin
                    r_go <= 1'b1;
                    if (r_exp == '0) begin
                        r_opx   <= r_a;
                        r_opy   <= r_acc;
                        r_state <= S_FIN;
                    end else if (r_exp[0]) begin
                        r_opx   <= r_acc;
                        r_opy   <= r_base;
                        r_state <= S_MACC;
                    end else begin
                        r_opx   <= r_base;
                        r_opy   <= r_base;
                        r_state <= S_MSQ;
                    end
                end
                S_MACC: begin
                    if (s_mm.done) begin
                        r_acc <= w_res;
                        // last exponent bit: the square would go unused
                        if (r_exp[MOD_WIDTH-1:1] == '0) begin
                            r_exp   <= '0;
                            r_state <= S_STEP;
                        end else begin
                            r_opx   <= r_base;
                            r_opy   <= r_base;
                            r_go    <= 1'b1;
                            r_state <= S_MSQ;
                        end
                    end
                end
                S_MSQ: begin
                    if (s_mm.done) begin
                        r_base  <= w_res;
                        r_exp   <= r_exp >> 1;
                        r_state <= S_STEP;
                    end
                end
                S_FIN: begin
                    if (s_mm.done) begin
                        r_q     <= w_res;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_m_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE) && !s_mm.busy;
    assign o_m_tvalid = (r_state == S_OUT);
    assign o_m_tdata  = OUT_W'(r_q);

endmodule

[hw/rtl/mdf_mulmod.sv]
// bit-serial modular multiplier: res = (x * y) mod m, one bit of y per cycle
// depends on mdf_pkg; x must be below m, y may be any value of MOD_WIDTH bits
module mdf_mulmod import mdf_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [MOD_WIDTH-1:0] i_x,
    input  logic [MOD_WIDTH-1:0] i_y,
    input  logic [MOD_WIDTH-1:0] i_mod,
    output t_mm_stat             o_stat,
    output logic [MOD_WIDTH-1:0] o_res
);

    localparam int CW = $clog2(MOD_WIDTH);
    localparam int TW = MOD_WIDTH + 2;

    logic                 r_busy;
    logic                 r_done;
    logic [MOD_WIDTH-1:0] r_r;
    logic [MOD_WIDTH-1:0] r_x;
    logic [MOD_WIDTH-1:0] r_y;
    logic [CW-1:0]        r_cnt;
    logic [MOD_WIDTH-1:0] n_r;

    logic [TW-1:0] w_t;
    logic [TW-1:0] w_m1;
    logic [TW-1:0] w_m2;

    // one horner step: t = 2r + bit*x, below 3m, then subtract 0, m or 2m
    always_comb begin
        w_m1 = TW'(i_mod);
        w_m2 = TW'({i_mod, 1'b0});
        w_t  = TW'({r_r, 1'b0}) + (r_y[MOD_WIDTH-1] ? TW'(r_x) : TW'(0));
        if (w_t >= w_m2) begin
            n_r = MOD_WIDTH'(w_t - w_m2);
        end else if (w_t >= w_m1) begin
            n_r = MOD_WIDTH'(w_t - w_m1);
        end else begin
            n_r = MOD_WIDTH'(w_t);
        end
    end

    // operand load and bit sequencing, msb of y first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_r    <= '0;
                r_x    <= i_x;
                r_y    <= i_y;
                r_cnt  <= CW'(MOD_WIDTH - 1);
            end else if (r_busy) begin
                r_r   <= n_r;
                r_y   <= {r_y[MOD_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = r_r;

endmodule

[hw/rtl/mdf_checker.sv]
// port-level checks for the modular division block, bound to the top level
// depends on mdf_pkg and modular_division_fermat_assert.svh
`include "modular_division_fermat_assert.svh"

module mdf_checker import mdf_pkg::*; #(
    parameter int MOD_WIDTH = MOD_WIDTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_tvalid,
    input logic                               o_s_tready,
    input logic                               o_m_tvalid,
    input logic                               i_m_tready,
    input logic [((MOD_WIDTH+7)/8)*8-1:0]     o_m_tdata
);

    // a stalled result beat stays and holds its data
    `MDF_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // one item at a time: no input taken while a result is shown
    `MDF_ASSERT_NOW(a_one_item, o_m_tvalid, !o_s_tready)

    // an accepted input closes the input side
    `MDF_ASSERT_NEXT(a_in_close, i_s_tvalid && o_s_tready, !o_s_tready)

    // a delivered result reopens the input side at once
    `MDF_ASSERT_NEXT(a_reopen, o_m_tvalid && i_m_tready, o_s_tready && !o_m_tvalid)

endmodule

bind modular_division_fermat mdf_checker #(
    .MOD_WIDTH (MOD_WIDTH)
) u_mdf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
